// File: design/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: design/mbrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbrd_pkg;

  localparam int AXES_DEFAULT = 3;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam int          CENTI_DIVISOR   = 10;
  localparam int          HEADER_BYTES    = 2;
  localparam logic [8:0]  COUNTER_MAX     = 9'd511;
  localparam logic [15:0] MAG_MAX         = 16'hFFFF;
  localparam logic [31:0] SAT_LIMIT       = 32'(CENTI_DIVISOR * 65536);
  localparam logic [19:0] RECIP_TENTH     = 20'd838861;
  localparam int          RECIP_SHIFT     = 23;

  localparam logic [15:0] SCALE_RESET    = 16'd1;
  localparam logic [7:0]  CAPACITY_RESET = 8'd64;

  typedef enum logic [0:0] {
    REG_SCALE    = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_SAMPLE      = 2'd0,
    ST_RAW         = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_INVALID     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_DIV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// File: design/modbus_axis_response_decoder.sv
// Modbus read-holding-registers response decoder.
// Input channel: one PDU byte per transaction (data_byte, frame_end on the
// final byte); the block raises in_stall while it works on a finished frame.
// Mid-frame bytes are taken one per cycle and give no result.
// Output channel: one transaction per result. A frame with function 0x03,
// byte count 2*AXES and length 2+2*AXES gives AXES sample results, the last
// with last set; any other frame gives one status result with last set.
// Sequencing: a status result is registered at the edge that takes the final
// byte. Each sample axis uses one shared multiplier: the scale multiply, a
// saturation check, then a reciprocal multiply for the divide by ten, which a
// saturated axis skips. These steps start once the final byte or the previous
// result is taken; the result is registered by the divide step, or by the
// check step when it saturates.
// The block takes no new byte until the last result of a frame is taken.
// When the receiver stalls, the result register holds and the sequencer waits.
// Reset: scale 1, raw-frame capacity 64, byte counter and header cleared,
// sequencer idle with no result pending.
// Configuration: cfg_we writes cfg_data into register cfg_index.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module modbus_axis_response_decoder #(
  parameter int AXES = mbrd_pkg::AXES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               frame_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [2:0]              axis_index,
  output logic signed [15:0]      raw_value,
  output logic [15:0]             mag_centi_g,
  output logic                    last
);

  localparam int AX_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [8:0] SAMPLE_LEN = 9'(mbrd_pkg::HEADER_BYTES + 2 * AXES);
  localparam logic [7:0] SAMPLE_COUNT = 8'(2 * AXES);
  localparam logic [2:0] LAST_AXIS = 3'(AXES - 1);

  mbrd_pkg::state_t state, state_next;

  logic [15:0] scale_milli_g_per_lsb;
  logic [7:0]  raw_frame_capacity;

  logic [8:0]  byte_counter;
  logic [7:0]  function_code;
  logic [7:0]  declared_byte_count;
  logic [7:0]  pending_high_byte;
  logic [15:0] axis_readings [AXES];

  logic [2:0]  axis;
  logic [31:0] product;

  logic        in_accept;
  logic        out_accept;
  logic [8:0]  offset;
  logic [7:0]  slot;
  logic [8:0]  len;
  logic        is_sample;
  logic [15:0] cur_raw;
  logic [15:0] cur_mag;
  logic [19:0] mul_a;
  logic [19:0] mul_b;
  logic [39:0] mul_p;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (state != mbrd_pkg::S_IDLE);

  assign offset = byte_counter - 9'(mbrd_pkg::HEADER_BYTES);
  assign slot   = offset[8:1];
  assign len    = (byte_counter < mbrd_pkg::COUNTER_MAX) ? byte_counter + 9'd1 : byte_counter;
  assign is_sample = (function_code == mbrd_pkg::FN_READ_HOLDING) &&
                     (declared_byte_count == SAMPLE_COUNT) && (len == SAMPLE_LEN);

  assign cur_raw = axis_readings[axis[AX_IDX_W-1:0]];
  assign cur_mag = cur_raw[15] ? (~cur_raw + 16'd1) : cur_raw;

  always_comb begin
    if (state == mbrd_pkg::S_DIV) begin
      mul_a = product[19:0];
      mul_b = mbrd_pkg::RECIP_TENTH;
    end else begin
      mul_a = {4'd0, cur_mag};
      mul_b = {4'd0, scale_milli_g_per_lsb};
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbrd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mbrd_pkg::S_IDLE: begin
        if (in_accept && frame_end) begin
          if (len >= 9'(mbrd_pkg::HEADER_BYTES) && is_sample) begin
            state_next = mbrd_pkg::S_MUL;
          end else begin
            state_next = mbrd_pkg::S_OUT;
          end
        end
      end
      mbrd_pkg::S_MUL: state_next = mbrd_pkg::S_CHK;
      mbrd_pkg::S_CHK: begin
        if (product >= mbrd_pkg::SAT_LIMIT) begin
          state_next = mbrd_pkg::S_OUT;
        end else begin
          state_next = mbrd_pkg::S_DIV;
        end
      end
      mbrd_pkg::S_DIV: state_next = mbrd_pkg::S_OUT;
      mbrd_pkg::S_OUT: begin
        if (out_accept) begin
          if (last) begin
            state_next = mbrd_pkg::S_IDLE;
          end else begin
            state_next = mbrd_pkg::S_MUL;
          end
        end
      end
      default: state_next = mbrd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_milli_g_per_lsb <= mbrd_pkg::SCALE_RESET;
      raw_frame_capacity    <= mbrd_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mbrd_pkg::REG_SCALE:    scale_milli_g_per_lsb <= cfg_data;
        mbrd_pkg::REG_CAPACITY: raw_frame_capacity    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter        <= '0;
      function_code       <= '0;
      declared_byte_count <= '0;
      pending_high_byte   <= '0;
    end else if (in_accept) begin
      if (byte_counter == 9'd0) begin
        function_code <= data_byte;
      end else if (byte_counter == 9'd1) begin
        declared_byte_count <= data_byte;
      end else if (!offset[0]) begin
        pending_high_byte <= data_byte;
      end
      byte_counter <= frame_end ? 9'd0 : len;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && byte_counter > 9'd1 && offset[0] && slot < 8'(AXES)) begin
      axis_readings[slot[AX_IDX_W-1:0]] <= {pending_high_byte, data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_accept) begin
        out_valid <= 1'b0;
      end
      if (state == mbrd_pkg::S_IDLE && in_accept && frame_end) begin
        axis        <= 3'd0;
        axis_index  <= 3'd0;
        raw_value   <= '0;
        mag_centi_g <= '0;
        last        <= 1'b1;
        if (len < 9'(mbrd_pkg::HEADER_BYTES)) begin
          status    <= mbrd_pkg::ST_INVALID;
          out_valid <= 1'b1;
        end else if (is_sample) begin
          status <= mbrd_pkg::ST_SAMPLE;
        end else if (len <= {1'b0, raw_frame_capacity}) begin
          status    <= mbrd_pkg::ST_RAW;
          out_valid <= 1'b1;
        end else begin
          status    <= mbrd_pkg::ST_UNSUPPORTED;
          out_valid <= 1'b1;
        end
      end
      if (state == mbrd_pkg::S_MUL) begin
        product    <= mul_p[31:0];
        axis_index <= axis;
        raw_value  <= cur_raw;
        last       <= (axis == LAST_AXIS);
      end
      if (state == mbrd_pkg::S_CHK) begin
        if (product >= mbrd_pkg::SAT_LIMIT) begin
          mag_centi_g <= mbrd_pkg::MAG_MAX;
          out_valid   <= 1'b1;
        end
      end
      if (state == mbrd_pkg::S_DIV) begin
        mag_centi_g <= mul_p[mbrd_pkg::RECIP_SHIFT +: 16];
        out_valid   <= 1'b1;
      end
      if (state == mbrd_pkg::S_OUT && out_accept && !last) begin
        axis <= axis + 3'd1;
      end
    end
  end

  `ASSERT_IMPLY(a_idle_no_result, !in_stall, !out_valid,
    "result pending while input is open")
  `ASSERT_NEXT(a_last_reopens, out_valid && !out_stall && last, !in_stall,
    "input not reopened after last result")
  `ASSERT_IMPLY(a_status_single, out_valid && status != mbrd_pkg::ST_SAMPLE, last,
    "status result without last")
  `ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid && $stable(mag_centi_g),
    "result changed while stalled")

endmodule

`default_nettype wire
